// ===== design/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_assert.svh
// Assertion macros for the double-ended queue; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define DQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("double_ended_queue: invariant violated");
`define DQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("double_ended_queue: sequence violated");
`else
`define DQ_ASSERT_ALWAYS(lbl, cond)
`define DQ_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== design/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  // Shown for front and rear when nothing is stored.
  localparam word_t EMPTY_MARK = -32'sd32768;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_VIEW       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Per-chain command, broadcast to every cell in the same cycle.
  typedef struct packed {
    logic shr;  // take left neighbor, cell 0 takes the pushed word
    logic shl;  // take right neighbor
    logic ins;  // cell at the fill position takes the pushed word
  } cell_ctl_t;

endpackage

// ===== design/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One word of a storage chain: hold, load, or take a neighbor's word.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      load_here,
  input  word_t     left_word,
  input  word_t     right_word,
  input  word_t     load_word,
  output word_t     word
);

  always_ff @(posedge clk) begin
    if (ctl.ins && load_here) begin
      word <= load_word;
    end else if (ctl.shr) begin
      word <= left_word;
    end else if (ctl.shl) begin
      word <= right_word;
    end
  end

endmodule

// ===== design/dq_chain.sv =====
// ----------------------------------------------------------------------------
// dq_chain
// Row of cells ordered from one end of the queue; cell 0 is that end.
// ----------------------------------------------------------------------------
module dq_chain import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [OCC_W-1:0] occupancy,
  input  word_t            data_value,
  output word_t            end_word
);

  word_t words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    logic  load_here;

    if (i == 0) begin : g_first
      assign left_w = data_value;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    // Insert lands just past the last stored word of this chain.
    assign load_here = (occupancy == OCC_W'(i));

    dq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_here  (load_here),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (data_value),
      .word       (words[i])
    );
  end

  assign end_word = words[0];

endmodule

// ===== design/double_ended_queue.sv =====
// An action's result is registered and shown in the cycle after it is taken.
// Throughput: one action per cycle; a push shifts one of two cell chains
// (front and rear ordered) and inserts in the other, a pop shifts one.
// Input stalls only while a result is shown and its consumer stalls.
// Reset clears the word count and the result valid; cell words stay as they
// are and are never shown before being written.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words with one result per request.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          action,
  input  logic signed [31:0]  data_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic signed [31:0]  front_value,
  output logic signed [31:0]  rear_value,
  output logic [COUNT_W-1:0]  count,
  output logic                is_empty
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  status_t          status_reg;
  status_t          status_next;
  cell_ctl_t        front_ctl;
  cell_ctl_t        rear_ctl;
  word_t            front_word;
  word_t            rear_word;
  logic             accept;
  logic             full;
  logic             empty;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (occupancy == OCC_W'(DEPTH));
  assign empty    = (occupancy == '0);

  always_comb begin
    front_ctl      = '0;
    rear_ctl       = '0;
    occupancy_next = occupancy;
    status_next    = ST_OK;
    case (action_t'(action))
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_OVER;
        end else begin
          front_ctl.shr  = 1'b1;
          rear_ctl.ins   = 1'b1;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end
      ACT_PUSH_REAR: begin
        if (full) begin
          status_next = ST_OVER;
        end else begin
          rear_ctl.shr   = 1'b1;
          front_ctl.ins  = 1'b1;
          occupancy_next = occupancy + OCC_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_UNDER;
        end else begin
          front_ctl.shl  = 1'b1;
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
      ACT_POP_REAR: begin
        if (empty) begin
          status_next = ST_UNDER;
        end else begin
          rear_ctl.shl   = 1'b1;
          occupancy_next = occupancy - OCC_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // Drop the command when no request is taken.
    if (!accept) begin
      front_ctl      = '0;
      rear_ctl       = '0;
      occupancy_next = occupancy;
    end
  end

  dq_chain #(.DEPTH(DEPTH)) u_front_chain (
    .clk        (clk),
    .ctl        (front_ctl),
    .occupancy  (occupancy),
    .data_value (data_value),
    .end_word   (front_word)
  );

  dq_chain #(.DEPTH(DEPTH)) u_rear_chain (
    .clk        (clk),
    .ctl        (rear_ctl),
    .occupancy  (occupancy),
    .data_value (data_value),
    .end_word   (rear_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg <= status_next;
    end
  end

  // State only moves on an accepted request, so these hold while stalled.
  assign status      = status_reg;
  assign front_value = empty ? EMPTY_MARK : front_word;
  assign rear_value  = empty ? EMPTY_MARK : rear_word;
  assign is_empty    = empty;

  if (OCC_W >= COUNT_W) begin : g_cnt_trunc
    assign count = occupancy[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign count = COUNT_W'(occupancy);
  end

  `DQ_ASSERT_ALWAYS(a_occ_bound, occupancy <= OCC_W'(DEPTH))
  `DQ_ASSERT_NEXT(a_under_holds, accept && status_next == ST_UNDER, $stable(occupancy))
  `DQ_ASSERT_NEXT(a_over_holds, accept && status_next == ST_OVER, $stable(occupancy))
  `DQ_ASSERT_NEXT(a_push_grows,
    accept && status_next == ST_OK &&
    (action == ACT_PUSH_FRONT || action == ACT_PUSH_REAR),
    occupancy == $past(occupancy) + OCC_W'(1))
  `DQ_ASSERT_NEXT(a_result_shown, accept, out_valid && status == $past(status_next))

endmodule
